// File: rtl/sorted_key_index_lookup_core_defines.svh
// Assertion macros for the sorted key index lookup core.
// Used by the top level; expects clk and rst_n in the including scope.
`ifndef SORTED_KEY_INDEX_LOOKUP_CORE_DEFINES_SVH
`define SORTED_KEY_INDEX_LOOKUP_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define SKIL_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("skil: invariant violated");
`define SKIL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("skil: same-cycle implication violated");
`define SKIL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("skil: next-cycle implication violated");
`else
`define SKIL_ASSERT(lbl, cond)
`define SKIL_ASSERT_IMP(lbl, ante, cons)
`define SKIL_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// File: rtl/skil_pkg.sv
// Package for the sorted key index lookup core: sizes, codes and payload types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package skil_pkg;

  localparam int MAX_ENTRIES = 1024;
  localparam int MAX_BLOCKS  = 256;
  localparam int OFFSET_BITS = 24;
  localparam int KEY_W       = 64;
  localparam int CANDIDATES  = 2;

  localparam int ENTRY_CNT_W = 11;
  localparam int BLOCK_CNT_W = 9;
  localparam int SLOT_W      = 11;
  localparam int BLK_NUM_W   = 8;

  localparam int KEY_AW = $clog2(MAX_ENTRIES);
  localparam int VAL_AW = $clog2(MAX_ENTRIES + 1);
  localparam int BLK_AW = $clog2(MAX_BLOCKS + 1);
  localparam int POS_W  = $clog2(MAX_ENTRIES + 1);
  localparam int K_W    = $clog2(MAX_BLOCKS + 1);

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_LOAD_KEY   = 2'd0;
  localparam kind_t KIND_LOAD_BLOCK = 2'd1;
  localparam kind_t KIND_SEARCH     = 2'd2;

  typedef logic cfg_index_t;
  localparam cfg_index_t CFG_ENTRY_COUNT = 1'b0;
  localparam cfg_index_t CFG_BLOCK_COUNT = 1'b1;

  typedef struct packed {
    kind_t                  kind;
    logic [SLOT_W-1:0]      slot;
    logic [KEY_W-1:0]       key;
    logic [OFFSET_BITS-1:0] byte_offset;
  } in_item_t;

  typedef struct packed {
    logic                   found;
    logic [BLK_NUM_W-1:0]   block_number;
    logic [OFFSET_BITS-1:0] offset_in_block;
    logic [OFFSET_BITS-1:0] value_length;
  } out_item_t;

  typedef struct packed {
    logic lt;
    logic eq;
    logic gt;
  } cmp_res_t;

endpackage

`default_nettype wire

// File: rtl/skil_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module skil_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: rtl/skil_cmp.sv
// Shared compare and offset subtract unit of the lookup sequencer.
// Depends on skil_pkg.
`timescale 1ns / 1ps
`default_nettype none

module skil_cmp (
  input  logic [skil_pkg::KEY_W-1:0]       op_a,
  input  logic [skil_pkg::KEY_W-1:0]       op_b,
  output skil_pkg::cmp_res_t               res,
  output logic [skil_pkg::OFFSET_BITS-1:0] diff
);
  import skil_pkg::*;

  always_comb begin
    res.lt = (op_a < op_b);
    res.gt = (op_a > op_b);
    res.eq = (op_a == op_b);
    diff   = op_a[OFFSET_BITS-1:0] - op_b[OFFSET_BITS-1:0];
  end

endmodule

`default_nettype wire

// File: rtl/sorted_key_index_lookup_core.sv
// Top level of the sorted key index lookup core: sequencer, stores, config.
// Depends on skil_pkg, skil_ram, skil_cmp and the assertion macro header.
//
// Usage:
//   Input: drive in_data and raise start; the item transfers at a clock edge
//   with start high and busy low. Load items (key entry, block start) write
//   their store in that cycle, give no result and keep busy low. A search
//   raises busy until its result is out. Kind 3 is dropped.
//   Result: out_data is valid for exactly one cycle while out_valid is high.
//   The receiver cannot stall; the result transfers in that cycle.
//   Config: cfg_we with cfg_index 0 (entry count) or 1 (block count) writes
//   cfg_wdata at the clock edge; write only while busy is low.
//   Search: a search makes P binary probes and a block walk of W steps (P up to 9
//   for 1024 keys, W up to block count - 1). Every step goes through the one
//   registered read port of a store and the shared compare unit. An empty
//   index answers in the cycle after the transfer.
//   Reset: rst_n low at a clock edge returns to idle with entry and block
//   counts of one; store contents are undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_key_index_lookup_core_defines.svh"

module sorted_key_index_lookup_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  skil_pkg::in_item_t               in_data,
  output logic                             out_valid,
  output skil_pkg::out_item_t              out_data,
  input  logic                             cfg_we,
  input  skil_pkg::cfg_index_t             cfg_index,
  input  logic [skil_pkg::ENTRY_CNT_W-1:0] cfg_wdata
);
  import skil_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_PROBE, S_CMP, S_C0W, S_C1W, S_V0, S_V1, S_V2, S_W0, S_W1, S_B0, S_B1
  } state_t;

  state_t                 state_r;
  logic [ENTRY_CNT_W-1:0] entry_count_r;
  logic [BLOCK_CNT_W-1:0] block_count_r;
  logic [KEY_W-1:0]       key_r;
  logic [POS_W-1:0]       left_r, right_r, mid_r, pos_r;
  logic [K_W-1:0]         k_r, nb_r;
  logic [OFFSET_BITS-1:0] vstart_r, vend_r, len_r;
  logic                   out_valid_r;
  out_item_t              out_data_r;

  logic [POS_W-1:0]       n_sat, span, mid;
  logic [K_W-1:0]         nb_sat, k_inc;
  logic                   accept, walk_more;

  logic                   key_we, val_we, blk_we;
  logic [KEY_AW-1:0]      key_raddr;
  logic [VAL_AW-1:0]      val_raddr;
  logic [BLK_AW-1:0]      blk_raddr;
  logic [KEY_W-1:0]       key_rdata;
  logic [OFFSET_BITS-1:0] val_rdata, blk_rdata;

  logic [KEY_W-1:0]       op_a, op_b;
  cmp_res_t               cmp_res;
  logic [OFFSET_BITS-1:0] cmp_diff;

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);

  assign n_sat = (entry_count_r > ENTRY_CNT_W'(MAX_ENTRIES)) ? POS_W'(MAX_ENTRIES)
                                                              : POS_W'(entry_count_r);
  assign nb_sat = (block_count_r > BLOCK_CNT_W'(MAX_BLOCKS)) ? K_W'(MAX_BLOCKS) :
                  (block_count_r == '0) ? K_W'(1) : K_W'(block_count_r);

  assign span      = right_r - left_r;
  assign mid       = left_r + (span >> 1);
  assign k_inc     = k_r + K_W'(1);
  assign walk_more = (k_inc < nb_r);

  // Store writes on load transfers
  assign key_we = accept && (in_data.kind == KIND_LOAD_KEY) &&
                  (in_data.slot < SLOT_W'(MAX_ENTRIES));
  assign val_we = accept && (in_data.kind == KIND_LOAD_KEY) &&
                  (in_data.slot <= SLOT_W'(MAX_ENTRIES));
  assign blk_we = accept && (in_data.kind == KIND_LOAD_BLOCK) &&
                  (in_data.slot <= SLOT_W'(MAX_BLOCKS));

  always_comb begin
    key_raddr = left_r[KEY_AW-1:0];
    val_raddr = VAL_AW'(pos_r);
    blk_raddr = BLK_AW'(k_r);
    unique case (state_r)
      S_PROBE: key_raddr = (span > POS_W'(CANDIDATES)) ? mid[KEY_AW-1:0]
                                                       : left_r[KEY_AW-1:0];
      S_C0W:   key_raddr = KEY_AW'(right_r - POS_W'(1));
      S_V1:    val_raddr = VAL_AW'(pos_r) + VAL_AW'(1);
      S_W0:    blk_raddr = walk_more ? BLK_AW'(k_inc) : BLK_AW'(k_r);
      default: ;
    endcase
  end

  skil_ram #(.WIDTH(KEY_W), .DEPTH(MAX_ENTRIES)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (in_data.slot[KEY_AW-1:0]),
    .wdata (in_data.key),
    .raddr (key_raddr),
    .rdata (key_rdata)
  );

  skil_ram #(.WIDTH(OFFSET_BITS), .DEPTH(MAX_ENTRIES + 1)) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (VAL_AW'(in_data.slot)),
    .wdata (in_data.byte_offset),
    .raddr (val_raddr),
    .rdata (val_rdata)
  );

  skil_ram #(.WIDTH(OFFSET_BITS), .DEPTH(MAX_BLOCKS + 1)) u_blk_ram (
    .clk   (clk),
    .we    (blk_we),
    .waddr (BLK_AW'(in_data.slot)),
    .wdata (in_data.byte_offset),
    .raddr (blk_raddr),
    .rdata (blk_rdata)
  );

  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (state_r)
      S_CMP, S_C0W, S_C1W: begin
        op_a = key_rdata;
        op_b = key_r;
      end
      S_V2: begin
        op_a = KEY_W'(val_rdata);
        op_b = KEY_W'(vstart_r);
      end
      S_W1: begin
        op_a = KEY_W'(vend_r);
        op_b = KEY_W'(blk_rdata);
      end
      S_B1: begin
        op_a = KEY_W'(vstart_r);
        op_b = KEY_W'(blk_rdata);
      end
      default: ;
    endcase
  end

  skil_cmp u_cmp (
    .op_a (op_a),
    .op_b (op_b),
    .res  (cmp_res),
    .diff (cmp_diff)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      entry_count_r <= ENTRY_CNT_W'(1);
      block_count_r <= BLOCK_CNT_W'(1);
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ENTRY_COUNT: entry_count_r <= cfg_wdata;
          CFG_BLOCK_COUNT: block_count_r <= cfg_wdata[BLOCK_CNT_W-1:0];
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept && (in_data.kind == KIND_SEARCH)) begin
            key_r   <= in_data.key;
            nb_r    <= nb_sat;
            left_r  <= '0;
            right_r <= n_sat;
            if (n_sat == '0) begin
              out_valid_r <= 1'b1;
              out_data_r  <= '0;
            end else begin
              state_r <= S_PROBE;
            end
          end
        end
        S_PROBE: begin
          if (span > POS_W'(CANDIDATES)) begin
            mid_r   <= mid;
            state_r <= S_CMP;
          end else begin
            state_r <= S_C0W;
          end
        end
        S_CMP: begin
          priority if (cmp_res.lt) begin
            left_r  <= mid_r;
            state_r <= S_PROBE;
          end else if (cmp_res.gt) begin
            right_r <= mid_r;
            state_r <= S_PROBE;
          end else begin
            pos_r   <= mid_r;
            state_r <= S_V0;
          end
        end
        S_C0W: begin
          if (cmp_res.eq) begin
            pos_r   <= left_r;
            state_r <= S_V0;
          end else begin
            state_r <= S_C1W;
          end
        end
        S_C1W: begin
          if (cmp_res.eq) begin
            pos_r   <= right_r - POS_W'(1);
            state_r <= S_V0;
          end else begin
            out_valid_r <= 1'b1;
            out_data_r  <= '0;
            state_r     <= S_IDLE;
          end
        end
        S_V0: state_r <= S_V1;
        S_V1: begin
          vstart_r <= val_rdata;
          state_r  <= S_V2;
        end
        S_V2: begin
          vend_r  <= val_rdata;
          len_r   <= cmp_diff;
          k_r     <= '0;
          state_r <= S_W0;
        end
        S_W0: state_r <= walk_more ? S_W1 : S_B1;
        S_W1: begin
          if (cmp_res.gt) begin
            k_r     <= k_inc;
            state_r <= S_W0;
          end else begin
            state_r <= S_B0;
          end
        end
        S_B0: state_r <= S_B1;
        S_B1: begin
          out_valid_r                <= 1'b1;
          out_data_r.found           <= 1'b1;
          out_data_r.block_number    <= BLK_NUM_W'(k_r);
          out_data_r.offset_in_block <= cmp_diff;
          out_data_r.value_length    <= len_r;
          state_r                    <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `SKIL_ASSERT_IMP(a_out_when_idle, out_valid, !busy)
  `SKIL_ASSERT_NXT(a_search_busy, accept && (in_data.kind == KIND_SEARCH) && (n_sat != '0), busy)
  `SKIL_ASSERT_IMP(a_miss_zero, out_valid && !out_data.found, (out_data.block_number == '0) && (out_data.offset_in_block == '0) && (out_data.value_length == '0))
  `SKIL_ASSERT_IMP(a_window_open, state_r == S_PROBE, right_r > left_r)
  `SKIL_ASSERT_IMP(a_walk_bound, (state_r == S_W0) || (state_r == S_W1), k_r < nb_r)

endmodule

`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for sorted_key_index_lookup_core: loads key and block tables,
// runs searches under random idle gaps and checks every answer against a local lookup model.
// Depends on skil_pkg and the core RTL.

module tb_top;
  import skil_pkg::*;

  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES = 600;
  localparam int LIMIT_CYCLES = 1_500_000;
  localparam logic [KEY_W-1:0] KEY_MAX = '1;

  typedef enum logic [1:0] {OP_ITEM, OP_CFG, OP_DRAIN} stim_kind_e;

  typedef struct {
    stim_kind_e op;
    in_item_t item;
    cfg_index_t idx;
    logic [ENTRY_CNT_W-1:0] wdata;
  } stim_op_t;

  logic clk;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_item_t in_data = '0;
  logic out_valid;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  cfg_index_t cfg_index = CFG_ENTRY_COUNT;
  logic [ENTRY_CNT_W-1:0] cfg_wdata = '0;

  sorted_key_index_lookup_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // lookup model state
  logic [KEY_W-1:0] key_m [MAX_ENTRIES];
  logic [OFFSET_BITS-1:0] value_ofs_m [MAX_ENTRIES + 1];
  logic [OFFSET_BITS-1:0] block_start_m [MAX_BLOCKS + 1];
  logic [ENTRY_CNT_W-1:0] entry_cnt_m = 1;
  logic [BLOCK_CNT_W-1:0] block_cnt_m = 1;
  out_item_t lookup_answers_q[$];

  // stimulus side
  stim_op_t pending_ops[$];
  logic [KEY_W-1:0] gen_keys [MAX_ENTRIES];
  int searches_made = 0;
  int ops_sent = 0;
  int quiet_cycles = 0;
  int mismatch_count = 0;
  int cycle_cnt = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic out_item_t locate_value(int pos);
    int nb;
    int k;
    logic [OFFSET_BITS-1:0] vstart;
    logic [OFFSET_BITS-1:0] vend;
    out_item_t r;
    nb = (block_cnt_m > MAX_BLOCKS) ? MAX_BLOCKS : int'(block_cnt_m);
    if (nb == 0) nb = 1;
    k = 0;
    vstart = value_ofs_m[pos];
    vend = value_ofs_m[pos + 1];
    while (k + 1 < nb && vend > block_start_m[k + 1]) k++;
    r.found = 1'b1;
    r.block_number = 8'(k);
    r.offset_in_block = vstart - block_start_m[k];
    r.value_length = vend - vstart;
    return r;
  endfunction

  function automatic void lookup_step(in_item_t it);
    out_item_t r;
    int n;
    int lo;
    int hi;
    int mid;
    bit hit;
    case (it.kind)
      KIND_LOAD_KEY: begin
        if (it.slot < MAX_ENTRIES) key_m[it.slot] = it.key;
        if (it.slot <= MAX_ENTRIES) value_ofs_m[it.slot] = it.byte_offset;
      end
      KIND_LOAD_BLOCK: begin
        if (it.slot <= MAX_BLOCKS) block_start_m[it.slot] = it.byte_offset;
      end
      KIND_SEARCH: begin
        r = '0;
        n = (entry_cnt_m > MAX_ENTRIES) ? MAX_ENTRIES : int'(entry_cnt_m);
        if (n != 0) begin
          lo = 0;
          hi = n;
          hit = 1'b0;
          while (!hit && hi - lo > CANDIDATES) begin
            mid = lo + (hi - lo) / 2;
            if (key_m[mid] < it.key) lo = mid;
            else if (key_m[mid] > it.key) hi = mid;
            else begin
              r = locate_value(mid);
              hit = 1'b1;
            end
          end
          if (!hit) begin
            if (key_m[lo] == it.key) r = locate_value(lo);
            else if (key_m[hi - 1] == it.key) r = locate_value(hi - 1);
          end
        end
        lookup_answers_q.push_back(r);
      end
      default: ;
    endcase
  endfunction

  function automatic void config_write(cfg_index_t idx, logic [ENTRY_CNT_W-1:0] v);
    if (idx == CFG_ENTRY_COUNT) entry_cnt_m = v;
    else block_cnt_m = v[BLOCK_CNT_W-1:0];
  endfunction

  function automatic void check_field(string fname, logic [63:0] got, logic [63:0] want);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s expected %0h actual %0h", $time, fname, want, got);
    end
  endfunction

  // stimulus builders
  task automatic push_op(stim_kind_e op, in_item_t item, cfg_index_t idx,
                         logic [ENTRY_CNT_W-1:0] wdata);
    stim_op_t o;
    o.op = op;
    o.item = item;
    o.idx = idx;
    o.wdata = wdata;
    pending_ops.push_back(o);
  endtask

  task automatic push_item(kind_t kind, int slot, logic [KEY_W-1:0] key,
                           logic [OFFSET_BITS-1:0] ofs);
    in_item_t it;
    it.kind = kind;
    it.slot = SLOT_W'(slot);
    it.key = key;
    it.byte_offset = ofs;
    if (kind == KIND_LOAD_KEY && slot < MAX_ENTRIES) gen_keys[slot] = key;
    if (kind == KIND_SEARCH) searches_made++;
    push_op(OP_ITEM, it, CFG_ENTRY_COUNT, '0);
  endtask

  task automatic push_drain();
    push_op(OP_DRAIN, '0, CFG_ENTRY_COUNT, '0);
  endtask

  task automatic push_cfg(cfg_index_t idx, int v);
    push_op(OP_CFG, '0, idx, ENTRY_CNT_W'(v));
  endtask

  task automatic push_noise();
    case ($urandom_range(0, 2))
      0: push_item(2'd3, $urandom_range(0, 2047), {$urandom, $urandom}, $urandom);
      1: push_item(KIND_LOAD_KEY, $urandom_range(MAX_ENTRIES + 1, 2047),
                   {$urandom, $urandom}, $urandom);
      default: push_item(KIND_LOAD_BLOCK, $urandom_range(MAX_BLOCKS + 1, 2047),
                         {$urandom, $urandom}, $urandom);
    endcase
  endtask

  task automatic load_table(int n, int nb);
    logic [KEY_W-1:0] k;
    logic [KEY_W-1:0] span;
    logic [OFFSET_BITS-1:0] v;
    logic [OFFSET_BITS-1:0] first;
    logic [OFFSET_BITS-1:0] b;
    int len_max;
    int bsz;
    int i;
    bit scramble;
    scramble = ($urandom_range(0, 4) == 0);
    k = {$urandom, $urandom} >> $urandom_range(1, 63);
    span = (KEY_MAX - k) / (n + 1);
    if ($urandom_range(0, 2) == 0) span = 3;
    len_max = $urandom_range(1, 4096);
    v = $urandom;
    first = v;
    for (i = 0; i <= n; i++) begin
      push_item(KIND_LOAD_KEY, i, k, scramble ? OFFSET_BITS'($urandom) : v);
      if ($urandom_range(0, 11) == 0) push_noise();
      k += ($urandom_range(0, 19) == 0) ? 64'd0 : 64'd1 + ({$urandom, $urandom} % span);
      v += OFFSET_BITS'($urandom_range(0, len_max));
    end
    bsz = (n * len_max / 2) / nb + 1;
    b = first - OFFSET_BITS'($urandom_range(0, bsz));
    for (i = 0; i <= nb; i++) begin
      push_item(KIND_LOAD_BLOCK, i, {$urandom, $urandom},
                scramble ? OFFSET_BITS'($urandom) : b);
      if ($urandom_range(0, 11) == 0) push_noise();
      b += OFFSET_BITS'($urandom_range(1, 2 * bsz));
    end
  endtask

  task automatic run_searches(int n, int count);
    logic [KEY_W-1:0] key;
    int r;
    int c;
    for (c = 0; c < count; c++) begin
      r = $urandom_range(0, 99);
      if (n > 0 && r < 60) begin
        key = gen_keys[$urandom_range(0, n - 1)];
      end else if (n > 0 && r < 80) begin
        key = gen_keys[$urandom_range(0, n - 1)];
        key = $urandom_range(0, 1) ? key + 64'd1 : key - 64'd1;
      end else begin
        key = {$urandom, $urandom};
      end
      push_item(KIND_SEARCH, $urandom_range(0, 2047), key, $urandom);
      if ($urandom_range(0, 11) == 0) push_noise();
      if ($urandom_range(0, 29) == 0) push_drain();
    end
  endtask

  task automatic table_phase(int n, int nb, int count);
    push_drain();
    push_cfg(CFG_ENTRY_COUNT, n);
    push_cfg(CFG_BLOCK_COUNT, nb);
    load_table(n, nb);
    run_searches(n, count);
  endtask

  task automatic directed_items();
    // reset counts: one entry, one block
    push_item(KIND_LOAD_KEY, 0, '0, '0);
    push_item(KIND_LOAD_KEY, 1, KEY_MAX, '1);
    push_item(KIND_LOAD_BLOCK, 0, '0, '0);
    push_item(KIND_SEARCH, 0, '0, '0);
    push_item(KIND_SEARCH, 2047, KEY_MAX, '1);
    push_item(2'd3, 2047, KEY_MAX, '1);
    push_item(KIND_LOAD_KEY, 2047, KEY_MAX, '1);
    push_item(KIND_LOAD_KEY, MAX_ENTRIES + 1, KEY_MAX, '1);
    push_item(KIND_LOAD_BLOCK, 2047, KEY_MAX, '1);
    push_item(KIND_LOAD_BLOCK, MAX_BLOCKS + 1, '0, '1);
    // block start above value start: offset wraps
    push_item(KIND_LOAD_BLOCK, 0, '0, 24'h000010);
    push_item(KIND_SEARCH, 0, '0, '0);
    push_item(KIND_LOAD_BLOCK, MAX_BLOCKS, KEY_MAX, '1);
    push_item(KIND_LOAD_KEY, MAX_ENTRIES, KEY_MAX, 24'h000123);
    // two entries; value end below value start: length wraps
    push_drain();
    push_cfg(CFG_ENTRY_COUNT, 2);
    push_item(KIND_LOAD_KEY, 2, 64'd5, 24'h000004);
    push_item(KIND_SEARCH, 0, KEY_MAX, '0);
    push_item(KIND_SEARCH, 0, 64'd1, '0);
    push_item(KIND_SEARCH, 0, 64'd5, '0);
    // empty index
    push_drain();
    push_cfg(CFG_ENTRY_COUNT, 0);
    push_item(KIND_SEARCH, 0, '0, '0);
    push_item(KIND_SEARCH, 0, KEY_MAX, '0);
  endtask

  // driver
  always @(posedge clk) begin : driver
    logic go_start;
    logic go_we;
    go_start = 1'b0;
    go_we = 1'b0;
    if (rst_n) begin
      if (start && !busy) lookup_step(in_data);
      if (start && busy) begin
        go_start = 1'b1;
      end else if (pending_ops.size() != 0) begin
        case (pending_ops[0].op)
          OP_DRAIN: begin
            if (!start && !busy && !out_valid && lookup_answers_q.size() == 0) quiet_cycles++;
            else quiet_cycles = 0;
            if (quiet_cycles >= SETTLE_CYCLES) begin
              quiet_cycles = 0;
              void'(pending_ops.pop_front());
            end
          end
          OP_CFG: begin
            go_we = 1'b1;
            cfg_index <= pending_ops[0].idx;
            cfg_wdata <= pending_ops[0].wdata;
            config_write(pending_ops[0].idx, pending_ops[0].wdata);
            void'(pending_ops.pop_front());
          end
          default: begin
            if ((ops_sent >= 150 && ops_sent < 450) || $urandom_range(0, 99) >= 20) begin
              go_start = 1'b1;
              in_data <= pending_ops[0].item;
              ops_sent++;
              void'(pending_ops.pop_front());
            end
          end
        endcase
      end
    end
    start <= go_start;
    cfg_we <= go_we;
  end

  // monitor
  always @(posedge clk) begin : monitor
    out_item_t want;
    if (rst_n && out_valid) begin
      if (lookup_answers_q.size() == 0) begin
        mismatch_count++;
        $display("%0t: expected no result, actual %p", $time, out_data);
      end else begin
        want = lookup_answers_q.pop_front();
        check_field("found", out_data.found, want.found);
        check_field("block_number", out_data.block_number, want.block_number);
        check_field("offset_in_block", out_data.offset_in_block, want.offset_in_block);
        check_field("value_length", out_data.value_length, want.value_length);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : stimulus
    int n;
    int nb;
    directed_items();
    table_phase($urandom_range(1, 24), $urandom_range(1, 8), 20);
    table_phase($urandom_range(1, 24), $urandom_range(1, 8), 20);
    table_phase(MAX_ENTRIES, MAX_BLOCKS, 30);
    // saturated counts on the full table
    push_drain();
    push_cfg(CFG_ENTRY_COUNT, 2047);
    push_cfg(CFG_BLOCK_COUNT, 511);
    run_searches(MAX_ENTRIES, 15);
    // block count of zero acts as one
    push_drain();
    push_cfg(CFG_BLOCK_COUNT, 11'h600);
    run_searches(MAX_ENTRIES, 10);
    push_drain();
    push_cfg(CFG_ENTRY_COUNT, 0);
    run_searches(0, 5);
    while (searches_made < 300) begin
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(25, 200) : $urandom_range(1, 24);
      nb = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 64) : $urandom_range(1, 8);
      table_phase(n, nb, $urandom_range(10, 25));
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_ops.size() != 0 || start || lookup_answers_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/skil_pkg.sv
rtl/skil_ram.sv
rtl/skil_cmp.sv
rtl/sorted_key_index_lookup_core.sv
dv/tb_top.sv
